[sv/pljt_pkg.sv]
`default_nettype none
package pljt_pkg;
  localparam int ANG_W    = 16;
  localparam int FORCE_W  = 24;
  localparam int LEN_W    = 16;
  localparam int TORQUE_W = 43;
  localparam int TRIG_W   = 17;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CORD_W   = 34;
  localparam int PHASE_W  = 32;
  localparam int TRIG_STAGES_DEF = 16;
  localparam int MAX_STAGES = 24;
  localparam logic [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_PROX_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_LEN = 1'b1;

  function automatic logic [PHASE_W-1:0] atan_entry(input int i);
    logic [PHASE_W-1:0] v;
    case (i)
      0: v = 32'd536870912;  1: v = 32'd316933406;  2: v = 32'd167458907;
      3: v = 32'd85004756;   4: v = 32'd42667331;   5: v = 32'd21354465;
      6: v = 32'd10679838;   7: v = 32'd5340245;    8: v = 32'd2670163;
      9: v = 32'd1335087;    10: v = 32'd667544;    11: v = 32'd333772;
      12: v = 32'd166886;    13: v = 32'd83443;     14: v = 32'd41721;
      15: v = 32'd20860;     16: v = 32'd10430;     17: v = 32'd5215;
      18: v = 32'd2607;      19: v = 32'd1303;      20: v = 32'd651;
      21: v = 32'd325;       22: v = 32'd162;       23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // per-cell cordic data for both angles
  typedef struct packed {
    logic signed [CORD_W-1:0]  x1;
    logic signed [CORD_W-1:0]  y1;
    logic signed [PHASE_W-1:0] z1;
    logic                      n1;
    logic signed [CORD_W-1:0]  x2;
    logic signed [CORD_W-1:0]  y2;
    logic signed [PHASE_W-1:0] z2;
    logic                      n2;
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fz;
  } cord_t;
endpackage
`default_nettype wire

[sv/pljt_if.sv]
`default_nettype none
interface pljt_in_if;
  import pljt_pkg::*;
  logic valid;
  logic ready;
  logic [ANG_W-1:0] proximal_angle;
  logic [ANG_W-1:0] distal_angle;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_z;
  modport source (output valid, proximal_angle, distal_angle, force_x, force_z, input ready);
  modport sink (input valid, proximal_angle, distal_angle, force_x, force_z, output ready);
endinterface

interface pljt_out_if;
  import pljt_pkg::*;
  logic valid;
  logic ready;
  logic signed [TORQUE_W-1:0] proximal_torque;
  logic signed [TORQUE_W-1:0] distal_torque;
  modport source (output valid, proximal_torque, distal_torque, input ready);
  modport sink (input valid, proximal_torque, distal_torque, output ready);
endinterface
`default_nettype wire

[sv/pljt_cell.sv]
`default_nettype none
module pljt_cell #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire pljt_pkg::cord_t d_in,
  output pljt_pkg::cord_t      d_r
);
  import pljt_pkg::*;
  localparam logic signed [PHASE_W-1:0] ATAN = atan_entry(IDX);
  cord_t d_nxt;

  always_comb begin
    d_nxt = d_in;
    if (!d_in.z1[PHASE_W-1]) begin
      d_nxt.x1 = d_in.x1 - (d_in.y1 >>> IDX);
      d_nxt.y1 = d_in.y1 + (d_in.x1 >>> IDX);
      d_nxt.z1 = d_in.z1 - ATAN;
    end else begin
      d_nxt.x1 = d_in.x1 + (d_in.y1 >>> IDX);
      d_nxt.y1 = d_in.y1 - (d_in.x1 >>> IDX);
      d_nxt.z1 = d_in.z1 + ATAN;
    end
    if (!d_in.z2[PHASE_W-1]) begin
      d_nxt.x2 = d_in.x2 - (d_in.y2 >>> IDX);
      d_nxt.y2 = d_in.y2 + (d_in.x2 >>> IDX);
      d_nxt.z2 = d_in.z2 - ATAN;
    end else begin
      d_nxt.x2 = d_in.x2 + (d_in.y2 >>> IDX);
      d_nxt.y2 = d_in.y2 - (d_in.x2 >>> IDX);
      d_nxt.z2 = d_in.z2 + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end
endmodule
`default_nettype wire

[sv/planar_two_link_jacobian_torque.sv]
`default_nettype none
// two-link planar jacobian-transpose torque pipeline
// in channel: proximal_angle, distal_angle (binary angles, 65536 = one turn)
//   and fingertip force_x, force_z (signed q15.8); one item per cycle
// out channel: proximal_torque, distal_torque (signed, 24 fraction bits)
// cfg port: index 0 proximal link length, index 1 distal link length (q0.16);
//   write only while idle
// throughput: one item per cycle while the receiver takes results, set by the chain of cordic cells, one
//   cell per rotation stage, and the registered multiply stages after it
// the whole pipe advances together; when the receiver stalls with a result
//   waiting, the pipe freezes and in_ready drops, nothing is lost
// reset clears all valid bits and loads the default link lengths
module planar_two_link_jacobian_torque
  import pljt_pkg::*;
#(
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  pljt_in_if.sink    in_ch,
  pljt_out_if.source out_ch,
  input wire logic                           cfg_we,
  input wire logic [pljt_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [pljt_pkg::CFG_W-1:0]     cfg_data
);
  // stages actually used
  localparam int NST = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;
  localparam int DEPTH = NST + 6;

  logic [LEN_W-1:0] lp_r, ld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= LEN_W'(3277);
      ld_r <= LEN_W'(2621);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROX_LEN: lp_r <= cfg_data;
        REG_DIST_LEN: ld_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // global pipe enable: advance unless the output holds an untaken result
  logic adv;
  logic [DEPTH-1:0] vld_r;
  assign adv = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  // stage 0: quadrant folding of both angles
  logic [ANG_W-1:0] a12;
  logic [PHASE_W-1:0] p1, p2;
  logic q1n, q2n;
  cord_t s0_nxt, s0_r;
  assign a12 = in_ch.proximal_angle + in_ch.distal_angle;
  assign p1  = {in_ch.proximal_angle, 16'h0000};
  assign p2  = {a12, 16'h0000};
  assign q1n = p1[31] ^ p1[30];
  assign q2n = p2[31] ^ p2[30];
  always_comb begin
    s0_nxt.x1 = CORDIC_GAIN;
    s0_nxt.y1 = '0;
    s0_nxt.z1 = q1n ? (p1 ^ 32'h8000_0000) : p1;
    s0_nxt.n1 = q1n;
    s0_nxt.x2 = CORDIC_GAIN;
    s0_nxt.y2 = '0;
    s0_nxt.z2 = q2n ? (p2 ^ 32'h8000_0000) : p2;
    s0_nxt.n2 = q2n;
    s0_nxt.fx = in_ch.force_x;
    s0_nxt.fz = in_ch.force_z;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  // chain of rotation cells
  cord_t chain [NST+1];
  assign chain[0] = s0_r;
  for (genvar i = 0; i < NST; i++) begin : g_cell
    pljt_cell #(.IDX(i)) u_cell (
      .clk (clk), .en (adv), .d_in (chain[i]), .d_r (chain[i+1])
    );
  end

  // rounding to q1.15 with saturation, sign fold
  function automatic logic signed [TRIG_W-1:0] rnd(input logic signed [CORD_W-1:0] v,
                                                   input logic neg);
    logic signed [CORD_W:0] t;
    logic signed [CORD_W:0] r;
    t = neg ? -$signed({v[CORD_W-1], v}) : $signed({v[CORD_W-1], v});
    r = (t + $signed((CORD_W+1)'(16384))) >>> 15;
    if (r > $signed((CORD_W+1)'(32768))) r = (CORD_W+1)'(32768);
    if (r < -$signed((CORD_W+1)'(32768))) r = -$signed((CORD_W+1)'(32768));
    return r[TRIG_W-1:0];
  endfunction

  cord_t ce;
  assign ce = chain[NST];
  logic signed [TRIG_W-1:0] s1_r, c1_r, s12_r, c12_r;
  logic signed [FORCE_W-1:0] fx1_r, fz1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r  <= rnd(ce.x1, ce.n1);
      s1_r  <= rnd(ce.y1, ce.n1);
      c12_r <= rnd(ce.x2, ce.n2);
      s12_r <= rnd(ce.y2, ce.n2);
      fx1_r <= ce.fx;
      fz1_r <= ce.fz;
    end
  end

  // lever arms q.31
  localparam int LV_W = 35;
  logic signed [LV_W-1:0] psx_r, pcz_r, dsx_r, dcz_r;
  logic signed [FORCE_W-1:0] fx2_r, fz2_r;
  logic signed [LV_W-1:0] ls1, lc1, ls12, lc12;
  assign ls1  = LV_W'($signed({1'b0, lp_r}) * s1_r);
  assign lc1  = LV_W'($signed({1'b0, lp_r}) * c1_r);
  assign ls12 = LV_W'($signed({1'b0, ld_r}) * s12_r);
  assign lc12 = LV_W'($signed({1'b0, ld_r}) * c12_r);
  logic signed [LV_W-1:0] ls1_r, lc1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ls1_r <= ls1;
      lc1_r <= lc1;
      dsx_r <= ls12;
      dcz_r <= lc12;
      fx2_r <= fx1_r;
      fz2_r <= fz1_r;
    end
  end
  logic signed [LV_W-1:0] dsx3_r, dcz3_r;
  logic signed [FORCE_W-1:0] fx3_r, fz3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      psx_r  <= ls1_r + dsx_r;
      pcz_r  <= lc1_r + dcz_r;
      dsx3_r <= dsx_r;
      dcz3_r <= dcz_r;
      fx3_r  <= fx2_r;
      fz3_r  <= fz2_r;
    end
  end

  // force products q.39
  localparam int PR_W = LV_W + FORCE_W;
  logic signed [PR_W-1:0] tpx_r, tpz_r, tdx_r, tdz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      tpx_r <= psx_r * fx3_r;
      tpz_r <= pcz_r * fz3_r;
      tdx_r <= dsx3_r * fx3_r;
      tdz_r <= dcz3_r * fz3_r;
    end
  end

  localparam int SM_W = PR_W + 1;
  logic signed [SM_W-1:0] sp, sd;
  assign sp = $signed({tpz_r[PR_W-1], tpz_r}) - $signed({tpx_r[PR_W-1], tpx_r})
            + SM_W'(16384);
  assign sd = $signed({tdz_r[PR_W-1], tdz_r}) - $signed({tdx_r[PR_W-1], tdx_r})
            + SM_W'(16384);
  logic signed [TORQUE_W-1:0] tp_r, td_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      tp_r <= sp[15 +: TORQUE_W];
      td_r <= sd[15 +: TORQUE_W];
    end
  end

  assign out_ch.valid           = vld_r[DEPTH-1];
  assign out_ch.proximal_torque = tp_r;
  assign out_ch.distal_torque   = td_r;
endmodule
`default_nettype wire
